// ----- rtl/core/thick_line_capsule_raster_unit_macros.svh -----
// assertion macros for the thick line capsule raster unit
`ifndef THICK_LINE_CAPSULE_RASTER_UNIT_MACROS_SVH
`define THICK_LINE_CAPSULE_RASTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLCR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TLCR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tlcr_pkg.sv -----
// shared types, codes, sine table and control store of the capsule raster unit
package tlcr_pkg;

	localparam int IMG_WIDTH  = 1024;
	localparam int IMG_HEIGHT = 1024;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [11:0] goto_x;
		logic signed [11:0] goto_y;
		logic signed [11:0] walk_length;
		logic [8:0]         heading_deg;
	} cmd_word_t;

	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [31:0] pixel_rgba;
		logic        pixel_write;
		logic        scan_done;
	} pix_word_t;

	localparam logic [1:0] MODE_GOTO = 2'd0;
	localparam logic [1:0] MODE_WALK = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_SKIP = 2'd3;

	localparam logic [1:0] REG_THICKNESS = 2'd0;
	localparam logic [1:0] REG_PEN_DOWN  = 2'd1;
	localparam logic [1:0] REG_COLOR     = 2'd2;

	// multiplier operand pairs
	localparam logic [3:0] MOP_NONE    = 4'd0;
	localparam logic [3:0] MOP_LEN_COS = 4'd1;
	localparam logic [3:0] MOP_LEN_SIN = 4'd2;
	localparam logic [3:0] MOP_WX_UX   = 4'd3;
	localparam logic [3:0] MOP_WY_UY   = 4'd4;
	localparam logic [3:0] MOP_WX_UY   = 4'd5;
	localparam logic [3:0] MOP_WY_UX   = 4'd6;
	localparam logic [3:0] MOP_WX_WX   = 4'd7;
	localparam logic [3:0] MOP_WY_WY   = 4'd8;
	localparam logic [3:0] MOP_EX_EX   = 4'd9;
	localparam logic [3:0] MOP_EY_EY   = 4'd10;
	localparam logic [3:0] MOP_P8_P8   = 4'd11;
	localparam logic [3:0] MOP_T_T     = 4'd12;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;
	localparam logic [1:0] ACC_SUB  = 2'd3;

	localparam logic [3:0] ACT_NONE     = 4'd0;
	localparam logic [3:0] ACT_GOTO     = 4'd1;
	localparam logic [3:0] ACT_IDLE_OUT = 4'd2;
	localparam logic [3:0] ACT_WALK_X   = 4'd3;
	localparam logic [3:0] ACT_WALK_Y   = 4'd4;
	localparam logic [3:0] ACT_WALK_BOX = 4'd5;
	localparam logic [3:0] ACT_LOAD_W   = 4'd6;
	localparam logic [3:0] ACT_SAVE_RSQ = 4'd7;
	localparam logic [3:0] ACT_LOAD_P8  = 4'd8;
	localparam logic [3:0] ACT_EMIT     = 4'd9;

	localparam logic [1:0] JMP_NEXT      = 2'd0;
	localparam logic [1:0] JMP_END       = 2'd1;
	localparam logic [1:0] JMP_START_CAP = 2'd2;
	localparam logic [1:0] JMP_END_CAP   = 2'd3;

	localparam logic [4:0] PC_GOTO = 5'd0;
	localparam logic [4:0] PC_IDLE = 5'd1;
	localparam logic [4:0] PC_W0   = 5'd2;
	localparam logic [4:0] PC_W1   = 5'd3;
	localparam logic [4:0] PC_W2   = 5'd4;
	localparam logic [4:0] PC_W3   = 5'd5;
	localparam logic [4:0] PC_T0   = 5'd6;
	localparam logic [4:0] PC_T1   = 5'd7;
	localparam logic [4:0] PC_T2   = 5'd8;
	localparam logic [4:0] PC_T3   = 5'd9;
	localparam logic [4:0] PC_T4   = 5'd10;
	localparam logic [4:0] PC_T5   = 5'd11;
	localparam logic [4:0] PC_T6   = 5'd12;
	localparam logic [4:0] PC_T7   = 5'd13;
	localparam logic [4:0] PC_T8   = 5'd14;
	localparam logic [4:0] PC_T9   = 5'd15;
	localparam logic [4:0] PC_T10  = 5'd16;
	localparam logic [4:0] PC_TS0  = 5'd17;
	localparam logic [4:0] PC_TS1  = 5'd18;
	localparam logic [4:0] PC_TS2  = 5'd19;
	localparam logic [4:0] PC_TS3  = 5'd20;
	localparam logic [4:0] PC_TE0  = 5'd21;
	localparam logic [4:0] PC_TE1  = 5'd22;
	localparam logic [4:0] PC_TE2  = 5'd23;
	localparam logic [4:0] PC_TE3  = 5'd24;

	typedef struct packed {
		logic [3:0] mop;
		logic [1:0] acc;
		logic [3:0] act;
		logic [1:0] jmp;
		logic [4:0] target;
	} ucode_t;

	// q14 sine of 0 to 90 degrees
	localparam logic [14:0] QUARTER_SINE [91] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// full-circle sine from the quarter table, degrees 0 to 359
	function automatic logic signed [15:0] sine_deg(input logic [8:0] d);
		logic [8:0]  k;
		logic        neg;
		logic [14:0] m;
		if (d <= 9'd90) begin
			k = d;
			neg = 1'b0;
		end else if (d <= 9'd180) begin
			k = 9'd180 - d;
			neg = 1'b0;
		end else if (d <= 9'd270) begin
			k = d - 9'd180;
			neg = 1'b1;
		end else begin
			k = 9'd360 - d;
			neg = 1'b1;
		end
		m = QUARTER_SINE[k[6:0]];
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic ucode_t ucw(input logic [3:0] mop, input logic [1:0] acc,
		input logic [3:0] act, input logic [1:0] jmp, input logic [4:0] target);
		ucode_t w;
		w.mop = mop;
		w.acc = acc;
		w.act = act;
		w.jmp = jmp;
		w.target = target;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input logic [4:0] pc);
		ucode_t w;
		case (pc)
			PC_GOTO: w = ucw(MOP_NONE, ACC_HOLD, ACT_GOTO, JMP_END, PC_GOTO);
			PC_IDLE: w = ucw(MOP_NONE, ACC_HOLD, ACT_IDLE_OUT, JMP_END, PC_GOTO);
			PC_W0:   w = ucw(MOP_LEN_COS, ACC_HOLD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_W1:   w = ucw(MOP_LEN_SIN, ACC_HOLD, ACT_WALK_X, JMP_NEXT, PC_GOTO);
			PC_W2:   w = ucw(MOP_NONE, ACC_HOLD, ACT_WALK_Y, JMP_NEXT, PC_GOTO);
			PC_W3:   w = ucw(MOP_NONE, ACC_HOLD, ACT_WALK_BOX, JMP_END, PC_GOTO);
			PC_T0:   w = ucw(MOP_NONE, ACC_HOLD, ACT_LOAD_W, JMP_NEXT, PC_GOTO);
			PC_T1:   w = ucw(MOP_WX_UX, ACC_HOLD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_T2:   w = ucw(MOP_WY_UY, ACC_LOAD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_T3:   w = ucw(MOP_T_T, ACC_ADD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_T4:   w = ucw(MOP_WX_UY, ACC_HOLD, ACT_SAVE_RSQ, JMP_START_CAP, PC_TS0);
			PC_T5:   w = ucw(MOP_WY_UX, ACC_LOAD, ACT_NONE, JMP_END_CAP, PC_TE0);
			PC_T6:   w = ucw(MOP_NONE, ACC_SUB, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_T7:   w = ucw(MOP_NONE, ACC_HOLD, ACT_LOAD_P8, JMP_NEXT, PC_GOTO);
			PC_T8:   w = ucw(MOP_P8_P8, ACC_HOLD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_T9:   w = ucw(MOP_NONE, ACC_LOAD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_T10:  w = ucw(MOP_NONE, ACC_HOLD, ACT_EMIT, JMP_END, PC_GOTO);
			PC_TS0:  w = ucw(MOP_WX_WX, ACC_HOLD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_TS1:  w = ucw(MOP_WY_WY, ACC_LOAD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_TS2:  w = ucw(MOP_NONE, ACC_ADD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_TS3:  w = ucw(MOP_NONE, ACC_HOLD, ACT_EMIT, JMP_END, PC_GOTO);
			PC_TE0:  w = ucw(MOP_EX_EX, ACC_HOLD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_TE1:  w = ucw(MOP_EY_EY, ACC_LOAD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_TE2:  w = ucw(MOP_NONE, ACC_ADD, ACT_NONE, JMP_NEXT, PC_GOTO);
			PC_TE3:  w = ucw(MOP_NONE, ACC_HOLD, ACT_EMIT, JMP_END, PC_GOTO);
			default: w = ucw(MOP_NONE, ACC_HOLD, ACT_NONE, JMP_END, PC_GOTO);
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/thick_line_capsule_raster_unit.sv -----
// thick line capsule raster unit: pen state, walk setup and per-pixel capsule test
// Commands arrive one word at a time and the command side stalls while a word is worked on.
// A go-to, a walk or a tick stalls the command side; a tick on an armed scan runs the start
// cap, end cap or segment body path, and mode 3 is taken without a stall and does nothing.
// That path is a small control program that runs every product of the distance test
// through one shared 23x23 multiplier with a registered product. A result word sits in
// an output register, so the next command is taken while it waits; an emitting step waits
// only while that register is full and stalled. Configuration is written through the APB
// port at byte addresses 0, 4 and 8; the user must do so only while the unit is idle, as
// the unit itself does not enforce it.
module thick_line_capsule_raster_unit import tlcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_word_t   cmd_word,
	output logic        pix_valid,
	input  logic        pix_stall,
	output pix_word_t   pix_word
);

	typedef struct packed {
		logic signed [13:0] lo;
		logic signed [13:0] hi;
	} span_t;

	localparam logic signed [13:0] X_LIM = 14'(IMG_WIDTH - 1);
	localparam logic signed [13:0] Y_LIM = 14'(IMG_HEIGHT - 1);
	localparam logic signed [20:0] CENTRE_X = 21'((IMG_WIDTH / 2) * 256);
	localparam logic signed [20:0] CENTRE_Y = 21'((IMG_HEIGHT / 2) * 256);

	function automatic logic signed [20:0] sat_fx(input logic signed [23:0] v);
		if (v > 24'sd1048575)
			return 21'sd1048575;
		else if (v < -24'sd1048576)
			return {1'b1, 20'b0};
		else
			return v[20:0];
	endfunction

	// one axis of the bounding box, widened and clipped
	function automatic span_t box_span(input logic signed [20:0] a, input logic signed [20:0] b,
		input logic [7:0] t, input logic signed [13:0] lim);
		logic signed [20:0] lo;
		logic signed [20:0] hi;
		logic signed [13:0] lo_m;
		logic signed [13:0] hi_m;
		span_t s;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		lo_m = {lo[20], lo[20:8]} - {6'b0, t};
		hi_m = {hi[20], hi[20:8]} + {6'b0, t};
		if (lo_m < 14'sd0)
			s.lo = 14'sd0;
		else if (lo_m > lim)
			s.lo = lim;
		else
			s.lo = lo_m;
		s.hi = (hi_m > lim) ? lim : hi_m;
		return s;
	endfunction

	logic [7:0]  thickness_q;
	logic        pen_down_q;
	logic [31:0] color_q;

	logic        busy_q;
	logic [4:0]  pc_q;
	ucode_t      cw;
	logic        cmd_take;
	logic        slot_free;
	logic        step_go;

	cmd_word_t          cmd_q;
	logic signed [15:0] cos_q;
	logic signed [15:0] sin_q;
	logic [8:0]         deg;
	logic [8:0]         cos_deg;
	logic [9:0]         deg_sum;
	logic [9:0]         deg_wrap;

	logic signed [20:0] pen_x_q;
	logic signed [20:0] pen_y_q;
	logic signed [20:0] start_x_q;
	logic signed [20:0] start_y_q;
	logic signed [20:0] end_x_q;
	logic signed [20:0] end_y_q;
	logic signed [15:0] dir_cos_q;
	logic signed [15:0] dir_sin_q;
	logic [11:0]        seg_len_q;
	logic [9:0]         col_q;
	logic [9:0]         row_q;
	logic [9:0]         min_col_q;
	logic [9:0]         max_col_q;
	logic [9:0]         min_row_q;
	logic [9:0]         max_row_q;
	logic               active_q;

	logic signed [21:0] wx_q;
	logic signed [21:0] wy_q;
	logic signed [21:0] ex_q;
	logic signed [21:0] ey_q;
	logic signed [22:0] p8_q;
	logic [15:0]        rsq_q;
	logic signed [45:0] prod_q;
	logic signed [47:0] acc_q;

	logic signed [22:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [45:0] prod;
	logic signed [47:0] prod_ext;
	logic signed [16:0] uy;

	logic signed [46:0] walk_rnd;
	logic signed [46:0] walk_sh;
	logic signed [21:0] walk_d;
	logic signed [23:0] sum_x;
	logic signed [23:0] sum_y;
	span_t              span_x;
	span_t              span_y;
	logic [11:0]        len_u;

	logic signed [21:0] px;
	logic signed [21:0] py;
	logic               start_cap;
	logic               end_cap;
	logic signed [47:0] p8_sum;
	logic signed [47:0] p8_sh;
	logic               covered;
	logic               wr;
	logic               last;

	logic        out_valid_q;
	pix_word_t   out_q;

	assign pready    = 1'b1;
	assign cmd_stall = busy_q;
	assign pix_valid = out_valid_q;
	assign pix_word  = out_q;

	always_comb begin
		case (paddr[3:2])
			REG_THICKNESS: prdata = {24'b0, thickness_q};
			REG_PEN_DOWN:  prdata = {31'b0, pen_down_q};
			REG_COLOR:     prdata = color_q;
			default:       prdata = 32'b0;
		endcase
	end

	assign cmd_take  = cmd_valid && !cmd_stall;
	assign slot_free = !out_valid_q || !pix_stall;
	assign cw        = ucode_rom(pc_q);
	assign step_go   = busy_q && ((cw.act != ACT_EMIT && cw.act != ACT_IDLE_OUT) || slot_free);

	// heading wrap and table lookups
	assign deg      = (cmd_word.heading_deg >= 9'd360) ? (cmd_word.heading_deg - 9'd360)
		: cmd_word.heading_deg;
	assign deg_sum  = {1'b0, deg} + 10'd90;
	assign deg_wrap = deg_sum - 10'd360;
	assign cos_deg  = (deg_sum >= 10'd360) ? deg_wrap[8:0] : deg_sum[8:0];

	assign uy = -{dir_sin_q[15], dir_sin_q};

	always_comb begin
		case (cw.mop)
			MOP_LEN_COS: begin
				mul_a = {{11{cmd_q.walk_length[11]}}, cmd_q.walk_length};
				mul_b = {{7{cos_q[15]}}, cos_q};
			end
			MOP_LEN_SIN: begin
				mul_a = {{11{cmd_q.walk_length[11]}}, cmd_q.walk_length};
				mul_b = {{7{sin_q[15]}}, sin_q};
			end
			MOP_WX_UX: begin
				mul_a = {wx_q[21], wx_q};
				mul_b = {{7{dir_cos_q[15]}}, dir_cos_q};
			end
			MOP_WY_UY: begin
				mul_a = {wy_q[21], wy_q};
				mul_b = {{6{uy[16]}}, uy};
			end
			MOP_WX_UY: begin
				mul_a = {wx_q[21], wx_q};
				mul_b = {{6{uy[16]}}, uy};
			end
			MOP_WY_UX: begin
				mul_a = {wy_q[21], wy_q};
				mul_b = {{7{dir_cos_q[15]}}, dir_cos_q};
			end
			MOP_WX_WX: begin
				mul_a = {wx_q[21], wx_q};
				mul_b = {wx_q[21], wx_q};
			end
			MOP_WY_WY: begin
				mul_a = {wy_q[21], wy_q};
				mul_b = {wy_q[21], wy_q};
			end
			MOP_EX_EX: begin
				mul_a = {ex_q[21], ex_q};
				mul_b = {ex_q[21], ex_q};
			end
			MOP_EY_EY: begin
				mul_a = {ey_q[21], ey_q};
				mul_b = {ey_q[21], ey_q};
			end
			MOP_P8_P8: begin
				mul_a = p8_q;
				mul_b = p8_q;
			end
			MOP_T_T: begin
				mul_a = {15'b0, thickness_q};
				mul_b = {15'b0, thickness_q};
			end
			default: begin
				mul_a = 23'sd0;
				mul_b = 23'sd0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_ext = {{2{prod_q[45]}}, prod_q};

	// rounded walk step from the registered product
	assign walk_rnd = {prod_q[45], prod_q} + 47'sd32;
	assign walk_sh  = walk_rnd >>> 6;
	assign walk_d   = walk_sh[21:0];
	assign sum_x    = {{3{pen_x_q[20]}}, pen_x_q} + {{2{walk_d[21]}}, walk_d};
	assign sum_y    = {{3{pen_y_q[20]}}, pen_y_q} - {{2{walk_d[21]}}, walk_d};
	assign len_u    = cmd_q.walk_length;

	assign span_x = box_span(start_x_q, end_x_q, thickness_q, X_LIM);
	assign span_y = box_span(start_y_q, end_y_q, thickness_q, Y_LIM);

	assign px = {4'b0, col_q, 8'b0};
	assign py = {4'b0, row_q, 8'b0};

	assign start_cap = (seg_len_q == 12'd0) || acc_q[47];
	assign end_cap   = acc_q > $signed({14'b0, seg_len_q, 22'b0});
	assign p8_sum    = acc_q + 48'sd8192;
	assign p8_sh     = p8_sum >>> 14;
	assign covered   = acc_q <= $signed({18'b0, rsq_q, 14'b0});
	assign wr        = pen_down_q && covered;
	assign last      = (col_q >= max_col_q) && (row_q >= max_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thickness_q <= 8'd1;
			pen_down_q  <= 1'b1;
			color_q     <= 32'b0;
			busy_q      <= 1'b0;
			pc_q        <= PC_GOTO;
			out_valid_q <= 1'b0;
			pen_x_q     <= CENTRE_X;
			pen_y_q     <= CENTRE_Y;
			start_x_q   <= 21'sd0;
			start_y_q   <= 21'sd0;
			end_x_q     <= 21'sd0;
			end_y_q     <= 21'sd0;
			dir_cos_q   <= 16'sd0;
			dir_sin_q   <= 16'sd0;
			seg_len_q   <= 12'd0;
			col_q       <= 10'd0;
			row_q       <= 10'd0;
			min_col_q   <= 10'd0;
			max_col_q   <= 10'd0;
			min_row_q   <= 10'd0;
			max_row_q   <= 10'd0;
			active_q    <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_THICKNESS: thickness_q <= pwdata[7:0];
					REG_PEN_DOWN:  pen_down_q <= pwdata[0];
					REG_COLOR:     color_q <= pwdata;
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall
				&& !(step_go && (cw.act == ACT_EMIT || cw.act == ACT_IDLE_OUT)))
				out_valid_q <= 1'b0;
			if (cmd_take) begin
				case (cmd_word.mode)
					MODE_GOTO: begin
						busy_q <= 1'b1;
						pc_q <= PC_GOTO;
					end
					MODE_WALK: begin
						busy_q <= 1'b1;
						pc_q <= PC_W0;
					end
					MODE_TICK: begin
						busy_q <= 1'b1;
						pc_q <= active_q ? PC_T0 : PC_IDLE;
					end
					default: ;
				endcase
			end else if (step_go) begin
				case (cw.act)
					ACT_GOTO: begin
						pen_x_q <= {cmd_q.goto_x[11], cmd_q.goto_x, 8'b0};
						pen_y_q <= {cmd_q.goto_y[11], cmd_q.goto_y, 8'b0};
					end
					ACT_WALK_X: begin
						start_x_q <= pen_x_q;
						end_x_q <= sat_fx(sum_x);
					end
					ACT_WALK_Y: begin
						start_y_q <= pen_y_q;
						end_y_q <= sat_fx(sum_y);
						if (cmd_q.walk_length[11]) begin
							dir_cos_q <= -cos_q;
							dir_sin_q <= -sin_q;
							seg_len_q <= ~len_u + 12'd1;
						end else begin
							dir_cos_q <= cos_q;
							dir_sin_q <= sin_q;
							seg_len_q <= len_u;
						end
					end
					ACT_WALK_BOX: begin
						min_col_q <= span_x.lo[9:0];
						max_col_q <= span_x.hi[9:0];
						min_row_q <= span_y.lo[9:0];
						max_row_q <= span_y.hi[9:0];
						active_q <= (span_x.lo <= span_x.hi) && (span_y.lo <= span_y.hi);
						col_q <= span_x.lo[9:0];
						row_q <= span_y.lo[9:0];
						pen_x_q <= end_x_q;
						pen_y_q <= end_y_q;
					end
					ACT_EMIT: begin
						out_valid_q <= 1'b1;
						if (last) begin
							active_q <= 1'b0;
						end else if (col_q >= max_col_q) begin
							col_q <= min_col_q;
							row_q <= row_q + 10'd1;
						end else begin
							col_q <= col_q + 10'd1;
						end
					end
					ACT_IDLE_OUT: out_valid_q <= 1'b1;
					default: ;
				endcase
				case (cw.jmp)
					JMP_NEXT:      pc_q <= pc_q + 5'd1;
					JMP_END:       busy_q <= 1'b0;
					JMP_START_CAP: pc_q <= start_cap ? cw.target : pc_q + 5'd1;
					JMP_END_CAP:   pc_q <= end_cap ? cw.target : pc_q + 5'd1;
					default:       busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd_word;
			cos_q <= sine_deg(cos_deg);
			sin_q <= sine_deg(deg);
		end
		if (step_go) begin
			if (cw.mop != MOP_NONE)
				prod_q <= prod;
			case (cw.acc)
				ACC_LOAD: acc_q <= prod_ext;
				ACC_ADD:  acc_q <= acc_q + prod_ext;
				ACC_SUB:  acc_q <= acc_q - prod_ext;
				default: ;
			endcase
			case (cw.act)
				ACT_LOAD_W: begin
					wx_q <= px - {start_x_q[20], start_x_q};
					wy_q <= py - {start_y_q[20], start_y_q};
					ex_q <= px - {end_x_q[20], end_x_q};
					ey_q <= py - {end_y_q[20], end_y_q};
				end
				ACT_SAVE_RSQ: rsq_q <= prod_q[15:0];
				ACT_LOAD_P8:  p8_q <= p8_sh[22:0];
				ACT_EMIT: begin
					out_q.pixel_x <= col_q;
					out_q.pixel_y <= row_q;
					out_q.pixel_rgba <= wr ? color_q : 32'b0;
					out_q.pixel_write <= wr;
					out_q.scan_done <= last;
				end
				ACT_IDLE_OUT: begin
					out_q.pixel_x <= 10'd0;
					out_q.pixel_y <= 10'd0;
					out_q.pixel_rgba <= 32'b0;
					out_q.pixel_write <= 1'b0;
					out_q.scan_done <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/tlcr_checker.sv -----
// port-level checks for the thick line capsule raster unit, bound to the top level
`include "thick_line_capsule_raster_unit_macros.svh"

module tlcr_checker import tlcr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input cmd_word_t cmd_word,
	input logic      pix_valid,
	input logic      pix_stall,
	input pix_word_t pix_word
);

	logic cmd_take;

	assign cmd_take = cmd_valid && !cmd_stall;

	// stalled result word holds
	`TLCR_ASSERT_NXT(a_pix_hold, clk, arst_n, pix_valid && pix_stall, pix_valid && $stable(pix_word), "result word changed under stall")

	// result word without write carries no colour
	`TLCR_ASSERT_IMP(a_no_write_no_color, clk, arst_n, pix_valid && !pix_word.pixel_write, pix_word.pixel_rgba == 32'b0, "color on a pixel without write")

	// go-to and walk words make no result
	`TLCR_ASSERT_NXT(a_no_extra_word, clk, arst_n, cmd_take && !pix_valid && (cmd_word.mode == MODE_GOTO || cmd_word.mode == MODE_WALK), !pix_valid, "result word from a command without result")

	// a working command blocks the next one
	`TLCR_ASSERT_NXT(a_busy_after_take, clk, arst_n, cmd_take && cmd_word.mode != MODE_SKIP, cmd_stall, "command side open while a word is in work")

endmodule

bind thick_line_capsule_raster_unit tlcr_checker u_tlcr_checker (.*);
